// File: rtl/throttle_failsafe_controller_core_defines.svh
// Assertion macros shared by the throttle failsafe controller RTL.
`ifndef THROTTLE_FAILSAFE_CONTROLLER_CORE_DEFINES_SVH
`define THROTTLE_FAILSAFE_CONTROLLER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge outside reset.
`define TFC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tfc implication check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define TFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tfc next-cycle check failed");
`else
`define TFC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/tfc_pkg.sv
// Shared types and constants of the throttle failsafe controller.
package tfc_pkg;

    // Default number of motors driven.
    localparam int MOTORS_DEFAULT = 4;

    // Field widths.
    localparam int COUNT_W  = 32;
    localparam int WIDTH_W  = 12;
    localparam int ADJ_W    = 17;
    localparam int CHECK_W  = 8;
    localparam int TICK_W   = 16;
    localparam int COEFF_W  = 16;
    localparam int FRAC_W   = 16;
    localparam int THR_W    = WIDTH_W + FRAC_W;
    localparam int SETTLE_W = WIDTH_W + COEFF_W + 1;
    localparam int FLAG_CNT = 6;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MIN_WIDTH       = 3'd0,
        CFG_LO_WIDTH        = 3'd1,
        CFG_WATCHDOG_CHECKS = 3'd2,
        CFG_LANDED_TICKS    = 3'd3,
        CFG_RECONNECT_TICKS = 3'd4,
        CFG_DECAY_COEFF     = 3'd5
    } cfg_reg_t;

    // Register reset values.
    localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST       = 12'd800;
    localparam logic [WIDTH_W-1:0] LO_WIDTH_RST        = 12'd1000;
    localparam logic [CHECK_W-1:0] WATCHDOG_CHECKS_RST = 8'd5;
    localparam logic [TICK_W-1:0]  LANDED_TICKS_RST    = 16'd400;
    localparam logic [TICK_W-1:0]  RECONNECT_TICKS_RST = 16'd100;
    localparam logic [COEFF_W-1:0] DECAY_COEFF_RST     = 16'd65309;

    // Unity in Q1.16 and one half in Q0.16.
    localparam logic [COEFF_W:0]   COEFF_ONE = 17'h10000;
    localparam logic [FRAC_W-1:0]  HALF_LSB  = 16'h8000;

    // Saturation limits.
    localparam logic [CHECK_W-1:0] CHECK_MAX = '1;
    localparam logic [TICK_W-1:0]  TICK_MAX  = '1;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX = '1;

    // Throttle after reset and the matching settle term target_width*(1-c).
    localparam logic [THR_W-1:0] THROTTLE_RST = {MIN_WIDTH_RST, {FRAC_W{1'b0}}};
    localparam logic [SETTLE_W-1:0] SETTLE_RST =
        SETTLE_W'(int'(MIN_WIDTH_RST) * (int'(COEFF_ONE) - int'(DECAY_COEFF_RST)));

    // Configuration as seen by the step logic.
    typedef struct packed {
        logic [WIDTH_W-1:0]  target_width;
        logic [WIDTH_W-1:0]  floor_width;
        logic [CHECK_W-1:0]  watchdog_checks;
        logic [TICK_W-1:0]   landed_ticks;
        logic [TICK_W-1:0]   reconnect_ticks;
        logic [COEFF_W-1:0]  decay_coeff;
        logic [SETTLE_W-1:0] settle_term;
    } cfg_t;

    // Flags of one result.
    typedef struct packed {
        logic drive_valid;
        logic capture_heading;
        logic halted;
        logic disarm;
        logic warning;
        logic in_failsafe_phase;
    } status_t;

endpackage

// File: rtl/tfc_cfg_regs.sv
// Configuration registers and the precomputed decay settle term.
module tfc_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [tfc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tfc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output tfc_pkg::cfg_t                   cfg
);
    import tfc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode a write; a change of the target width or decay_coeff refreshes the settle term.
    always_comb
    begin
        logic [WIDTH_W-1:0] new_min;
        logic [COEFF_W:0]   new_comp;
        new_min  = cfg_data[WIDTH_W-1:0];
        new_comp = COEFF_ONE - {1'b0, cfg_data};
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_MIN_WIDTH:
                begin
                    cfg_next.target_width = new_min;
                    cfg_next.settle_term  = SETTLE_W'(new_min)
                        * SETTLE_W'(COEFF_ONE - {1'b0, cfg_reg.decay_coeff});
                end
                CFG_LO_WIDTH:        cfg_next.floor_width     = cfg_data[WIDTH_W-1:0];
                CFG_WATCHDOG_CHECKS: cfg_next.watchdog_checks = cfg_data[CHECK_W-1:0];
                CFG_LANDED_TICKS:    cfg_next.landed_ticks    = cfg_data[TICK_W-1:0];
                CFG_RECONNECT_TICKS: cfg_next.reconnect_ticks = cfg_data[TICK_W-1:0];
                CFG_DECAY_COEFF:
                begin
                    cfg_next.decay_coeff = cfg_data[COEFF_W-1:0];
                    cfg_next.settle_term =
                        SETTLE_W'(cfg_reg.target_width) * SETTLE_W'(new_comp);
                end
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_width    <= MIN_WIDTH_RST;
            cfg_reg.floor_width     <= LO_WIDTH_RST;
            cfg_reg.watchdog_checks <= WATCHDOG_CHECKS_RST;
            cfg_reg.landed_ticks    <= LANDED_TICKS_RST;
            cfg_reg.reconnect_ticks <= RECONNECT_TICKS_RST;
            cfg_reg.decay_coeff     <= DECAY_COEFF_RST;
            cfg_reg.settle_term     <= SETTLE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/tfc_step.sv
// Controller state and the combinational tick step.
`include "throttle_failsafe_controller_core_defines.svh"
module tfc_step
#(
    parameter int MOTORS = tfc_pkg::MOTORS_DEFAULT
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               step_en,
    input  tfc_pkg::cfg_t                      cfg,
    input  logic [tfc_pkg::COUNT_W-1:0]        pulse_count,
    input  logic                               armed,
    input  logic                               battery_low,
    input  logic                               maybe_on_ground,
    input  logic signed [tfc_pkg::ADJ_W-1:0]   adjust [MOTORS],
    input  logic [tfc_pkg::WIDTH_W-1:0]        recent_width [MOTORS],
    output tfc_pkg::status_t                   status,
    output logic [tfc_pkg::WIDTH_W-1:0]        motor_width [MOTORS]
);
    import tfc_pkg::*;

    localparam int SUM_W    = WIDTH_W + $clog2(MOTORS);
    localparam int DECAY_W  = THR_W + COEFF_W + 2;
    localparam int DRV_W    = THR_W + 2;
    // Reciprocal of the motor count, exact for every sum below 2**SUM_W.
    localparam int RECIP_SH = SUM_W + 3;
    localparam int MEAN_W   = SUM_W + RECIP_SH + 1;
    localparam int RECIP    = ((1 << RECIP_SH) + MOTORS - 1) / MOTORS;

    // State registers.
    logic               fs_reg,         fs_next;
    logic               stopped_reg,    stopped_next;
    logic [COUNT_W-1:0] seen_reg,       seen_next;
    logic [CHECK_W-1:0] stale_reg,      stale_next;
    logic [TICK_W-1:0]  age_reg,        age_next;
    logic [TICK_W-1:0]  ground_reg,     ground_next;
    logic [THR_W-1:0]   throttle_reg,   throttle_next;
    logic               stale_flag_reg, stale_flag_next;

    // Datapath helpers.
    logic [THR_W-1:0]   lo_q;
    logic [THR_W:0]     stop_limit;
    logic [DECAY_W-1:0] decay_sum;
    logic [THR_W-1:0]   decay_val;
    logic [THR_W-1:0]   throttle_dec;
    logic [SUM_W-1:0]   width_sum;
    logic [MEAN_W-1:0]  mean_prod;
    logic [WIDTH_W-1:0] width_mean;
    logic [WIDTH_W-1:0] drive_width [MOTORS];
    logic               drive_on;

    // One decay step toward the target width, clamped at the floor width.
    always_comb
    begin
        lo_q       = {cfg.floor_width, {FRAC_W{1'b0}}};
        stop_limit = {1'b0, lo_q} + (THR_W+1)'(HALF_LSB);
        decay_sum  = DECAY_W'(throttle_reg) * DECAY_W'(cfg.decay_coeff)
                   + DECAY_W'({cfg.settle_term, {FRAC_W{1'b0}}})
                   + DECAY_W'(HALF_LSB);
        decay_val  = decay_sum[FRAC_W +: THR_W];
        throttle_dec = (decay_val < lo_q) ? lo_q : decay_val;
    end

    // Mean of the recent motor widths seeds the throttle on entry; the floor of the
    // quotient comes from a reciprocal multiply.
    always_comb
    begin
        width_sum = '0;
        for (int m = 0; m < MOTORS; m++)
        begin
            width_sum = width_sum + SUM_W'(recent_width[m]);
        end
        mean_prod  = MEAN_W'(width_sum) * MEAN_W'(RECIP);
        width_mean = mean_prod[RECIP_SH +: WIDTH_W];
    end

    // Per-motor width: decayed throttle plus correction, saturated.
    always_comb
    begin
        logic signed [DRV_W-1:0] t_sum;
        logic [DRV_W-FRAC_W-2:0] t_int;
        for (int m = 0; m < MOTORS; m++)
        begin
            t_sum = $signed({2'b00, throttle_dec}) + ($signed(DRV_W'(adjust[m])) <<< 10);
            t_int = t_sum[DRV_W-2:FRAC_W];
            if (t_sum[DRV_W-1])
            begin
                drive_width[m] = '0;
            end
            else if (t_int > (DRV_W-FRAC_W-1)'(WIDTH_MAX))
            begin
                drive_width[m] = WIDTH_MAX;
            end
            else
            begin
                drive_width[m] = t_int[WIDTH_W-1:0];
            end
        end
    end

    // Tick step: monitor check, failsafe entry, battery halt, disarm, decay and restart.
    always_comb
    begin
        logic [CHECK_W:0] stale_inc;
        logic [TICK_W-1:0] ground_upd;
        logic reconnect;
        fs_next         = fs_reg;
        stopped_next    = stopped_reg;
        seen_next       = seen_reg;
        stale_next      = stale_reg;
        age_next        = age_reg;
        ground_next     = ground_reg;
        throttle_next   = throttle_reg;
        stale_flag_next = stale_flag_reg;
        status          = '0;
        drive_on        = 1'b0;
        stale_inc       = {1'b0, stale_reg} + (CHECK_W+1)'(1);
        reconnect       = (seen_reg != pulse_count);
        if (maybe_on_ground && (throttle_reg == lo_q))
        begin
            ground_upd = (ground_reg == TICK_MAX) ? ground_reg : ground_reg + TICK_W'(1);
        end
        else
        begin
            ground_upd = '0;
        end

        if (stopped_reg)
        begin
            // Halted until reset.
        end
        else if (!fs_reg)
        begin
            if (pulse_count != '0)
            begin
                if (!reconnect)
                begin
                    stale_flag_next = 1'b1;
                    stale_next = stale_inc[CHECK_W] ? CHECK_MAX : stale_inc[CHECK_W-1:0];
                    if (stale_inc > {1'b0, cfg.watchdog_checks})
                    begin
                        fs_next                = 1'b1;
                        age_next               = '0;
                        ground_next            = '0;
                        throttle_next          = {width_mean, {FRAC_W{1'b0}}};
                        status.capture_heading = 1'b1;
                    end
                end
                else
                begin
                    stale_flag_next = 1'b0;
                    stale_next      = '0;
                end
                seen_next = pulse_count;
            end
        end
        else if (battery_low)
        begin
            status.disarm = 1'b1;
            stopped_next  = 1'b1;
        end
        else if (!armed)
        begin
            status.disarm = 1'b1;
        end
        else
        begin
            ground_next = ground_upd;
            if ((ground_upd > cfg.landed_ticks || age_reg < cfg.reconnect_ticks) && reconnect)
            begin
                fs_next    = 1'b0;
                seen_next  = pulse_count;
                stale_next = '0;
            end
            else
            begin
                age_next      = (age_reg == TICK_MAX) ? age_reg : age_reg + TICK_W'(1);
                throttle_next = throttle_dec;
                if ({1'b0, throttle_dec} < stop_limit)
                begin
                    status.disarm = 1'b1;
                end
                else
                begin
                    drive_on = 1'b1;
                end
            end
        end

        status.in_failsafe_phase = fs_next;
        status.warning           = stale_flag_next && !stopped_next;
        status.halted            = stopped_next;
        status.drive_valid       = drive_on;
    end

    // Widths are zero unless the motors are driven.
    always_comb
    begin
        for (int m = 0; m < MOTORS; m++)
        begin
            motor_width[m] = drive_on ? drive_width[m] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg         <= 1'b0;
            stopped_reg    <= 1'b0;
            seen_reg       <= '0;
            stale_reg      <= '0;
            age_reg        <= '0;
            ground_reg     <= '0;
            throttle_reg   <= THROTTLE_RST;
            stale_flag_reg <= 1'b0;
        end
        else if (step_en)
        begin
            fs_reg         <= fs_next;
            stopped_reg    <= stopped_next;
            seen_reg       <= seen_next;
            stale_reg      <= stale_next;
            age_reg        <= age_next;
            ground_reg     <= ground_next;
            throttle_reg   <= throttle_next;
            stale_flag_reg <= stale_flag_next;
        end
    end

    // Halt is permanent and only reachable from the failsafe phase.
    `TFC_ASSERT_NEXT(a_halt_sticky, clk, rst_n, stopped_reg, stopped_reg)
    `TFC_ASSERT_IMPLY(a_halt_in_failsafe, clk, rst_n, stopped_reg, fs_reg)
    // A tick never both drives and disarms the motors.
    `TFC_ASSERT_IMPLY(a_drive_excl, clk, rst_n, step_en, !(status.drive_valid && status.disarm))
    // Heading capture only on the monitor-to-failsafe transition, without drive.
    `TFC_ASSERT_IMPLY(a_capture_entry, clk, rst_n, step_en && status.capture_heading, !fs_reg && fs_next && !status.drive_valid)

endmodule

// File: rtl/throttle_failsafe_controller_core.sv
// Throttle failsafe controller: stream ports, input and result registers.
// Each tick passes through the input register and then the result register.
// Throughput: one tick per cycle while the result stream is not stalled; a
// stalled result holds the input register, and s_axis_tready falls only while
// both registers are full.
// Reset clears the pipeline valids and the controller state, and loads the
// configuration registers with their default values; no clearing pass.
module throttle_failsafe_controller_core
#(
    parameter int MOTORS = tfc_pkg::MOTORS_DEFAULT,
    localparam int IN_BITS  = tfc_pkg::COUNT_W + 3 + MOTORS * (tfc_pkg::ADJ_W + tfc_pkg::WIDTH_W),
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = tfc_pkg::FLAG_CNT + MOTORS * tfc_pkg::WIDTH_W,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write port.
    input  logic                            cfg_wr_en,
    input  logic [tfc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tfc_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Tick input stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata, low to high: pulse_count, armed, battery_low, maybe_on_ground,
    // adjust_0..adjust_(MOTORS-1), recent_width_0..recent_width_(MOTORS-1), zero fill.
    input  logic [IN_W-1:0]                 s_axis_tdata,
    // Result stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata, low to high: in_failsafe_phase, warning, disarm, halted,
    // capture_heading, drive_valid, motor_width_0..motor_width_(MOTORS-1), zero fill.
    output logic [OUT_W-1:0]                m_axis_tdata
);
    import tfc_pkg::*;

    localparam int ADJ_LSB = COUNT_W + 3;
    localparam int RW_LSB  = ADJ_LSB + MOTORS * ADJ_W;

    cfg_t cfg;

    logic               in_valid_reg;
    logic [IN_BITS-1:0] in_data_reg;
    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg;
    logic [OUT_W-1:0]   out_data_next;
    logic               step_load;

    logic signed [ADJ_W-1:0] in_adjust [MOTORS];
    logic [WIDTH_W-1:0]      in_recent [MOTORS];
    logic [WIDTH_W-1:0]      res_width [MOTORS];
    status_t                 res_status;

    tfc_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The result register takes a tick whenever it is empty or being drained.
    assign step_load     = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step_load;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata[IN_BITS-1:0];
        end
    end

    // Unpack the per-motor input fields.
    for (genvar m = 0; m < MOTORS; m++)
    begin : g_unpack
        assign in_adjust[m] = in_data_reg[ADJ_LSB + m*ADJ_W +: ADJ_W];
        assign in_recent[m] = in_data_reg[RW_LSB + m*WIDTH_W +: WIDTH_W];
    end

    tfc_step #(
        .MOTORS (MOTORS)
    ) u_step
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .step_en         (step_load),
        .cfg             (cfg),
        .pulse_count     (in_data_reg[COUNT_W-1:0]),
        .armed           (in_data_reg[COUNT_W]),
        .battery_low     (in_data_reg[COUNT_W+1]),
        .maybe_on_ground (in_data_reg[COUNT_W+2]),
        .adjust          (in_adjust),
        .recent_width    (in_recent),
        .status          (res_status),
        .motor_width     (res_width)
    );

    // Pack the result fields.
    always_comb
    begin
        out_data_next    = '0;
        out_data_next[0] = res_status.in_failsafe_phase;
        out_data_next[1] = res_status.warning;
        out_data_next[2] = res_status.disarm;
        out_data_next[3] = res_status.halted;
        out_data_next[4] = res_status.capture_heading;
        out_data_next[5] = res_status.drive_valid;
        for (int m = 0; m < MOTORS; m++)
        begin
            out_data_next[FLAG_CNT + m*WIDTH_W +: WIDTH_W] = res_width[m];
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
